FILE: rtl/mfpid_pkg.sv
package mfpid_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 12;
  localparam int GAIN_W     = 24;
  localparam int DATA_W     = 32;
  localparam int DIR_W      = 2;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int MULB_W     = DATA_W;
  localparam int PROD_W     = GAIN_W + MULB_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int BIAS_W     = 9;
  localparam int BAL_STEP   = 90;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_INC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PO  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_YAW = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DMAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DMIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMIN   = 3'd7;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_ADD,
    ALU_CLAMP,
    ALU_SHIFT
  } alu_op_e;

  typedef struct packed {
    alu_op_e                  op;
    logic signed [ACC_W-1:0]  operand;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
  } alu_ctl_t;

  typedef struct packed {
    logic                     go;
    logic signed [GAIN_W-1:0] a;
    logic signed [MULB_W-1:0] b;
  } mul_ctl_t;

  // Integral bias per direction code in balance mode
  function automatic logic signed [BIAS_W-1:0] dir_bias(logic [DIR_W-1:0] dir);
    case (dir)
      2'b01:   return BIAS_W'(BAL_STEP);
      2'b11:   return -BIAS_W'(BAL_STEP);
      2'b10:   return -BIAS_W'(2 * BAL_STEP);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: rtl/mfpid_mul.sv
module mfpid_mul
  import mfpid_pkg::*;
(
  input  logic                     clk_i,
  input  mul_ctl_t                 ctl_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // product holds until the next issue
  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      prod_q <= $signed(ctl_i.a) * $signed(ctl_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/mfpid_alu.sv
module mfpid_alu
  import mfpid_pkg::*;
(
  input  logic                    clk_i,
  input  alu_ctl_t                ctl_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] hi_x, lo_x;

  assign hi_x = $signed({{(ACC_W-DATA_W){ctl_i.hi[DATA_W-1]}}, ctl_i.hi});
  assign lo_x = $signed({{(ACC_W-DATA_W){ctl_i.lo[DATA_W-1]}}, ctl_i.lo});

  always_comb begin
    acc_d = acc_q;
    case (ctl_i.op)
      ALU_LOAD:  acc_d = $signed(ctl_i.operand);
      ALU_ADD:   acc_d = acc_q + $signed(ctl_i.operand);
      ALU_CLAMP: begin
        // upper bound wins when bounds cross
        if (acc_q > hi_x) begin
          acc_d = hi_x;
        end else if (acc_q < lo_x) begin
          acc_d = lo_x;
        end
      end
      ALU_SHIFT: acc_d = acc_q >>> FRAC_BITS;  // floor rescale
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/multi_form_pid_controller_top.sv
// Each input beat runs the microprogram of the mode, whose length in steps is:
//   incremental 5, positional/balance 10, proportional-outside 13,
//   yaw 4, unused codes 1. No new input beat is taken until the result of the last one
//   has moved into the output register. The steps share one 24x32 multiplier and one
//   accumulate/clamp ALU.
// Reset (async, active low): registers to defaults (mode positional, gains zero,
//   clamps full range), controller history cleared, output empty.
module multi_form_pid_controller_top
  import mfpid_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] measurement_i,
  input  logic signed [SAMPLE_W-1:0] target_i,
  input  logic signed [DIR_W-1:0]    direction_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DATA_W-1:0]   drive_o,
  // register write port
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [DATA_W-1:0]          cfg_data_i
);

  localparam int PC_W = 4;
  localparam int D1_W = ERR_W + 1;   // first difference
  localparam int D2_W = ERR_W + 2;   // second difference

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // multiplier gain select
  typedef enum logic [1:0] {G_P, G_I, G_D} gsel_e;
  // multiplier second operand select
  typedef enum logic [2:0] {B_E, B_DE, B_D2E, B_MEAS, B_DMEAS, B_ACC} bsel_e;
  // ALU operand source
  typedef enum logic [2:0] {S_PROD, S_SUM, S_E, S_EFRAC, S_BIAS, S_LOUT} src_e;
  // clamp bound pair
  typedef enum logic [1:0] {C_SAT, C_INT, C_DRV} csel_e;

  typedef struct packed {
    logic    mul_go;
    gsel_e   gsel;
    bsel_e   bsel;
    alu_op_e aop;
    src_e    src;
    csel_e   csel;
    logic    save_sum;
    logic    last;
  } uop_t;

  function automatic uop_t mk_uop(logic mg, gsel_e g, bsel_e b, alu_op_e a, src_e s,
                                  csel_e c, logic sv, logic l);
    uop_t r;
    r.mul_go   = mg;
    r.gsel     = g;
    r.bsel     = b;
    r.aop      = a;
    r.src      = s;
    r.csel     = c;
    r.save_sum = sv;
    r.last     = l;
    return r;
  endfunction

  // Microprogram. A product issued at step k is read from the product
  // register at step k+1 (or later if no multiply is issued in between).
  function automatic uop_t fetch(logic [MODE_W-1:0] md, logic [PC_W-1:0] pc);
    uop_t r;
    r = mk_uop(1'b0, G_P, B_E, ALU_NOP, S_PROD, C_SAT, 1'b0, 1'b1);
    case (md)
      MODE_INC: begin
        case (pc)
          0: r = mk_uop(1'b1, G_P, B_DE,  ALU_LOAD,  S_LOUT, C_SAT, 1'b0, 1'b0);
          1: r = mk_uop(1'b1, G_I, B_E,   ALU_ADD,   S_PROD, C_SAT, 1'b0, 1'b0);
          2: r = mk_uop(1'b1, G_D, B_D2E, ALU_ADD,   S_PROD, C_SAT, 1'b0, 1'b0);
          3: r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_PROD, C_SAT, 1'b0, 1'b0);
          default: r = mk_uop(1'b0, G_P, B_E, ALU_CLAMP, S_PROD, C_DRV, 1'b0, 1'b1);
        endcase
      end
      MODE_POS, MODE_BAL: begin
        case (pc)
          0: r = mk_uop(1'b0, G_P, B_E,   ALU_LOAD,  S_SUM,  C_SAT, 1'b0, 1'b0);
          1: r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_E,    C_SAT, 1'b0, 1'b0);
          2: r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_BIAS, C_SAT, 1'b0, 1'b0);
          3: r = mk_uop(1'b0, G_P, B_E,   ALU_CLAMP, S_PROD, C_SAT, 1'b0, 1'b0);
          4: r = mk_uop(1'b1, G_I, B_ACC, ALU_NOP,   S_PROD, C_SAT, 1'b1, 1'b0);
          5: r = mk_uop(1'b0, G_P, B_E,   ALU_LOAD,  S_PROD, C_SAT, 1'b0, 1'b0);
          6: r = mk_uop(1'b1, G_P, B_E,   ALU_CLAMP, S_PROD, C_INT, 1'b0, 1'b0);
          7: r = mk_uop(1'b1, G_D, B_DE,  ALU_ADD,   S_PROD, C_SAT, 1'b0, 1'b0);
          8: r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_PROD, C_SAT, 1'b0, 1'b0);
          default: r = mk_uop(1'b0, G_P, B_E, ALU_CLAMP, S_PROD, C_DRV, 1'b0, 1'b1);
        endcase
      end
      MODE_PO: begin
        case (pc)
          0:  r = mk_uop(1'b0, G_P, B_E,   ALU_LOAD,  S_SUM,   C_SAT, 1'b0, 1'b0);
          1:  r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_E,     C_SAT, 1'b0, 1'b0);
          2:  r = mk_uop(1'b0, G_P, B_E,   ALU_CLAMP, S_PROD,  C_SAT, 1'b0, 1'b0);
          3:  r = mk_uop(1'b1, G_I, B_ACC, ALU_NOP,   S_PROD,  C_SAT, 1'b1, 1'b0);
          4:  r = mk_uop(1'b0, G_P, B_E,   ALU_LOAD,  S_PROD,  C_SAT, 1'b0, 1'b0);
          5:  r = mk_uop(1'b1, G_D, B_DE,  ALU_CLAMP, S_PROD,  C_INT, 1'b0, 1'b0);
          6:  r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_EFRAC, C_SAT, 1'b0, 1'b0);
          7:  r = mk_uop(1'b0, G_P, B_E,   ALU_ADD,   S_PROD,  C_SAT, 1'b0, 1'b0);
          8:  r = mk_uop(1'b0, G_P, B_E,   ALU_CLAMP, S_PROD,  C_SAT, 1'b0, 1'b0);
          9:  r = mk_uop(1'b1, G_P, B_ACC, ALU_NOP,   S_PROD,  C_SAT, 1'b0, 1'b0);
          10: r = mk_uop(1'b0, G_P, B_E,   ALU_LOAD,  S_PROD,  C_SAT, 1'b0, 1'b0);
          11: r = mk_uop(1'b0, G_P, B_E,   ALU_SHIFT, S_PROD,  C_SAT, 1'b0, 1'b0);
          default: r = mk_uop(1'b0, G_P, B_E, ALU_CLAMP, S_PROD, C_DRV, 1'b0, 1'b1);
        endcase
      end
      MODE_YAW: begin
        case (pc)
          0: r = mk_uop(1'b1, G_P, B_MEAS,  ALU_NOP,  S_PROD, C_SAT, 1'b0, 1'b0);
          1: r = mk_uop(1'b1, G_D, B_DMEAS, ALU_LOAD, S_PROD, C_SAT, 1'b0, 1'b0);
          2: r = mk_uop(1'b0, G_P, B_E,     ALU_ADD,  S_PROD, C_SAT, 1'b0, 1'b0);
          default: r = mk_uop(1'b0, G_P, B_E, ALU_CLAMP, S_PROD, C_DRV, 1'b0, 1'b1);
        endcase
      end
      default: begin
        // unused mode: repeat the last drive, no clamp, history untouched
        r = mk_uop(1'b0, G_P, B_E, ALU_LOAD, S_LOUT, C_SAT, 1'b0, 1'b1);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]        mode_q;
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_W-1:0] drive_max_q, drive_min_q, integ_max_q, integ_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_POS;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      drive_max_q <= {1'b0, {(DATA_W-1){1'b1}}};
      drive_min_q <= {1'b1, {(DATA_W-1){1'b0}}};
      integ_max_q <= {1'b0, {(DATA_W-1){1'b1}}};
      integ_min_q <= {1'b1, {(DATA_W-1){1'b0}}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q      <= cfg_data_i[MODE_W-1:0];
        CFG_GAIN_P: gain_p_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I: gain_i_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D: gain_d_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_DMAX:   drive_max_q <= cfg_data_i;
        CFG_DMIN:   drive_min_q <= cfg_data_i;
        CFG_IMAX:   integ_max_q <= cfg_data_i;
        CFG_IMIN:   integ_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  uop_t              uop;
  logic              run;
  logic              in_beat;
  logic              out_load;
  logic              out_valid_q;

  assign uop      = fetch(mode_q, pc_q);
  assign run      = (state_q == ST_RUN);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat  = in_valid_i && (state_q == ST_IDLE);
  // the result moves into the output register once that register is free
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        if (uop.last) begin
          state_d = ST_DONE;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] meas_q;
  logic signed [ERR_W-1:0]    e_q;
  logic signed [BIAS_W-1:0]   bias_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      meas_q <= measurement_i;
      e_q    <= {target_i[SAMPLE_W-1], target_i}
              - {measurement_i[SAMPLE_W-1], measurement_i};
      bias_q <= (mode_q == MODE_BAL) ? dir_bias(direction_i) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller history
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]    last_err_q, prior_err_q;
  logic signed [DATA_W-1:0]   err_sum_q;
  logic signed [DATA_W-1:0]   last_out_q;
  logic signed [SAMPLE_W-1:0] last_meas_q;
  logic signed [ACC_W-1:0]    acc;
  logic                       err_mode;

  assign err_mode = (mode_q == MODE_INC) || (mode_q == MODE_POS)
                 || (mode_q == MODE_BAL) || (mode_q == MODE_PO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      prior_err_q <= '0;
      err_sum_q   <= '0;
      last_out_q  <= '0;
      last_meas_q <= '0;
    end else begin
      // saturated sum sits in the accumulator one step after its clamp
      if (run && uop.save_sum) begin
        err_sum_q <= acc[DATA_W-1:0];
      end
      if (out_load) begin
        last_out_q <= acc[DATA_W-1:0];
        if (err_mode) begin
          prior_err_q <= last_err_q;
          last_err_q  <= e_q;
        end
        if (mode_q == MODE_YAW) begin
          last_meas_q <= meas_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operand selection
  // ---------------------------------------------------------------------------
  logic signed [D1_W-1:0]   de;
  logic signed [D2_W-1:0]   d2e;
  logic signed [ERR_W-1:0]  dmeas;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  e_ext;
  mul_ctl_t                 mul_ctl;
  alu_ctl_t                 alu_ctl;

  assign de    = {e_q[ERR_W-1], e_q} - {last_err_q[ERR_W-1], last_err_q};
  assign d2e   = {{2{e_q[ERR_W-1]}}, e_q}
               - {last_err_q[ERR_W-1], last_err_q, 1'b0}
               + {{2{prior_err_q[ERR_W-1]}}, prior_err_q};
  assign dmeas = {meas_q[SAMPLE_W-1], meas_q} - {last_meas_q[SAMPLE_W-1], last_meas_q};
  assign e_ext = {{(ACC_W-ERR_W){e_q[ERR_W-1]}}, e_q};

  always_comb begin
    mul_ctl.go = run && uop.mul_go;
    case (uop.gsel)
      G_P:     mul_ctl.a = gain_p_q;
      G_I:     mul_ctl.a = gain_i_q;
      G_D:     mul_ctl.a = gain_d_q;
      default: mul_ctl.a = gain_p_q;
    endcase
    case (uop.bsel)
      B_E:     mul_ctl.b = {{(MULB_W-ERR_W){e_q[ERR_W-1]}}, e_q};
      B_DE:    mul_ctl.b = {{(MULB_W-D1_W){de[D1_W-1]}}, de};
      B_D2E:   mul_ctl.b = {{(MULB_W-D2_W){d2e[D2_W-1]}}, d2e};
      B_MEAS:  mul_ctl.b = {{(MULB_W-SAMPLE_W){meas_q[SAMPLE_W-1]}}, meas_q};
      B_DMEAS: mul_ctl.b = {{(MULB_W-ERR_W){dmeas[ERR_W-1]}}, dmeas};
      B_ACC:   mul_ctl.b = acc[MULB_W-1:0];
      default: mul_ctl.b = '0;
    endcase
  end

  always_comb begin
    alu_ctl.op = run ? uop.aop : ALU_NOP;
    case (uop.src)
      S_PROD:  alu_ctl.operand = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      S_SUM:   alu_ctl.operand = {{(ACC_W-DATA_W){err_sum_q[DATA_W-1]}}, err_sum_q};
      S_E:     alu_ctl.operand = e_ext;
      S_EFRAC: alu_ctl.operand = e_ext <<< FRAC_BITS;
      S_BIAS:  alu_ctl.operand = {{(ACC_W-BIAS_W){bias_q[BIAS_W-1]}}, bias_q};
      S_LOUT:  alu_ctl.operand = {{(ACC_W-DATA_W){last_out_q[DATA_W-1]}}, last_out_q};
      default: alu_ctl.operand = '0;
    endcase
    case (uop.csel)
      C_INT: begin
        alu_ctl.hi = integ_max_q;
        alu_ctl.lo = integ_min_q;
      end
      C_DRV: begin
        alu_ctl.hi = drive_max_q;
        alu_ctl.lo = drive_min_q;
      end
      default: begin
        // 32-bit saturation
        alu_ctl.hi = {1'b0, {(DATA_W-1){1'b1}}};
        alu_ctl.lo = {1'b1, {(DATA_W-1){1'b0}}};
      end
    endcase
  end

  mfpid_mul u_mul (
    .clk_i  (clk_i),
    .ctl_i  (mul_ctl),
    .prod_o (prod)
  );

  mfpid_alu u_alu (
    .clk_i (clk_i),
    .ctl_i (alu_ctl),
    .acc_o (acc)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds one finished beat while the sink stalls
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= acc[DATA_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

FILE: tb/tb.sv
module tb;
  import mfpid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes past yaw; the block treats them as hold-last-drive.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7f_ffff;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh80_0000;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sh00_1000;  // 1.0 in Q12.12
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_BACK = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_ODD  = 2'sb10;  // reads as -2

  // Covers the longest microprogram plus the output register, with a margin.
  localparam int SETTLE_CYCLES = 16;
  // Slowest legal gap between two beats: a LONG_HOLD output hold, a full item,
  // a stall burst and a register rewrite; taken several times over.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 80;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_W-1:0] measurement_i = '0;
  logic signed [SAMPLE_W-1:0] target_i = '0;
  logic signed [DIR_W-1:0] direction_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  multi_form_pid_controller_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .measurement_i (measurement_i),
    .target_i      (target_i),
    .direction_i   (direction_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_o       (drive_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Controller shadow: register copies and loop history, same reset values
  // as the block.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]          mode_r     = MODE_POS;
  logic signed [GAIN_W-1:0]   gain_p_r   = '0;
  logic signed [GAIN_W-1:0]   gain_i_r   = '0;
  logic signed [GAIN_W-1:0]   gain_d_r   = '0;
  logic signed [DATA_W-1:0]   drive_hi_r = S32_MAX;
  logic signed [DATA_W-1:0]   drive_lo_r = S32_MIN;
  logic signed [DATA_W-1:0]   integ_hi_r = S32_MAX;
  logic signed [DATA_W-1:0]   integ_lo_r = S32_MIN;

  logic signed [ERR_W-1:0]    last_err   = '0;
  logic signed [ERR_W-1:0]    prior_err  = '0;
  logic signed [DATA_W-1:0]   err_sum    = '0;
  logic signed [DATA_W-1:0]   last_drive = '0;
  logic signed [SAMPLE_W-1:0] last_meas  = '0;

  logic signed [DATA_W-1:0] pending_drives[$];
  int mismatch_count = 0;

  // Shared knobs for the handshake processes.
  bit idle_on = 1'b1;
  int long_hold_req = 0;
  int hold_left = 0;

  // Upper bound is tested first, so an inverted window gives hi for big values.
  function automatic longint clip(longint v, longint hi, longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One controller step: advances the shadow history, returns the drive.
  function automatic logic signed [DATA_W-1:0] pid_step(
      logic signed [SAMPLE_W-1:0] meas, logic signed [SAMPLE_W-1:0] tgt,
      logic signed [DIR_W-1:0] dir);
    longint e, u, integ, v, kp, ki, kd, le, pe;
    kp = longint'(gain_p_r);
    ki = longint'(gain_i_r);
    kd = longint'(gain_d_r);
    le = longint'(last_err);
    pe = longint'(prior_err);
    e  = longint'(tgt) - longint'(meas);
    if (mode_r > MODE_YAW) return last_drive;
    if (mode_r == MODE_YAW) begin
      u = kp * longint'(meas) + kd * (longint'(meas) - longint'(last_meas));
      last_meas = meas;
    end else begin
      if (mode_r == MODE_INC) begin
        u = longint'(last_drive) + kp * (e - le) + ki * e + kd * (e - 2 * le + pe);
      end else begin
        integ = longint'(err_sum) + e;
        if (mode_r == MODE_BAL) integ += longint'(dir) * BAL_STEP;
        err_sum = DATA_W'(clip(integ, S32_MAX, S32_MIN));
        integ = clip(ki * longint'(err_sum), integ_hi_r, integ_lo_r);
        if (mode_r == MODE_PO) begin
          v = clip(e * (longint'(1) <<< FRAC_BITS) + integ + kd * (e - le),
                   S32_MAX, S32_MIN);
          u = (kp * v) >>> FRAC_BITS;  // arithmetic shift: floor
        end else begin
          u = kp * e + integ + kd * (e - le);
        end
      end
      prior_err = last_err;
      last_err = ERR_W'(e);
    end
    last_drive = DATA_W'(clip(u, drive_hi_r, drive_lo_r));
    return last_drive;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Register writes: one per cycle, write enable left high between them.
  // ---------------------------------------------------------------------------
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:   mode_r     = data[MODE_W-1:0];
      CFG_GAIN_P: gain_p_r   = data[GAIN_W-1:0];
      CFG_GAIN_I: gain_i_r   = data[GAIN_W-1:0];
      CFG_GAIN_D: gain_d_r   = data[GAIN_W-1:0];
      CFG_DMAX:   drive_hi_r = data;
      CFG_DMIN:   drive_lo_r = data;
      CFG_IMAX:   integ_hi_r = data;
      CFG_IMIN:   integ_lo_r = data;
      default: ;
    endcase
  endtask

  // Called only with the block idle. History is kept across rewrites.
  task automatic configure(
      input logic [MODE_W-1:0] m,
      input logic signed [GAIN_W-1:0] kp, ki, kd,
      input logic signed [DATA_W-1:0] dmax, dmin, imax, imin);
    put_reg(CFG_MODE, DATA_W'(m));
    put_reg(CFG_GAIN_P, DATA_W'(kp));
    put_reg(CFG_GAIN_I, DATA_W'(ki));
    put_reg(CFG_GAIN_D, DATA_W'(kd));
    put_reg(CFG_DMAX, dmax);
    put_reg(CFG_DMIN, dmin);
    put_reg(CFG_IMAX, imax);
    put_reg(CFG_IMIN, imin);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one sample beat, with an optional idle burst in front.
  // Entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] meas,
                             input logic signed [SAMPLE_W-1:0] tgt,
                             input logic signed [DIR_W-1:0] dir);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    measurement_i <= meas;
    target_i      <= tgt;
    direction_i   <= dir;
    do @(posedge clk_i); while (in_stall_o);
    pending_drives.push_back(pid_step(meas, tgt, dir));
  endtask

  // Drop valid, wait for every drive to come back, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, or a long hold when one is requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (long_hold_req != 0) begin
      hold_left = long_hold_req;
      long_hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      hold_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Drive checker: every accepted beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("drive %0d with nothing pending", drive_o));
      end else if (drive_o !== pending_drives[0]) begin
        report_mismatch($sformatf("drive got %0d expected %0d", drive_o,
                                  pending_drives[0]));
        void'(pending_drives.pop_front());
      end else begin
        void'(pending_drives.pop_front());
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset values: positional form, zero gains, so the drive is zero.
  task automatic test_defaults();
    send_sample('0, '0, DIR_UP);
    send_sample(SMP_MIN, SMP_MAX, DIR_FWD);
    send_sample(SMP_MAX, SMP_MIN, DIR_ODD);
    settle();
  endtask

  // Positional form at the error extremes; integral carries over from above.
  task automatic test_positional();
    configure(MODE_POS, GAIN_ONE, 24'sd3, -GAIN_ONE, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_sample(SMP_MIN, SMP_MAX, DIR_UP);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    send_sample(16'sd100, 16'sd100, DIR_FWD);
    settle();
  endtask

  // Incremental form: builds on the last drive, second difference on D.
  task automatic test_incremental();
    configure(MODE_INC, GAIN_MAX, GAIN_MIN, GAIN_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    send_sample(SMP_MIN, SMP_MAX, DIR_BACK);
    send_sample(-16'sd7, 16'sd9, DIR_UP);
    settle();
  endtask

  // Balance velocity: every direction code, the odd pattern included.
  task automatic test_balance();
    configure(MODE_BAL, 24'sd2048, GAIN_ONE, 24'sd512, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_sample(16'sd10, 16'sd10, DIR_UP);
    send_sample(16'sd10, 16'sd10, DIR_FWD);
    send_sample(16'sd10, 16'sd10, DIR_BACK);
    send_sample(16'sd10, 16'sd10, DIR_ODD);
    settle();
  endtask

  // Proportional outside: integral clamped hard, inner sum pushed into saturation,
  // negative outer gain to exercise the floor on the rescale.
  task automatic test_prop_outside();
    configure(MODE_PO, -24'sd4097, GAIN_MAX, GAIN_MAX, S32_MAX, S32_MIN,
              S32_MAX, 32'sh4000_0000);
    send_sample(SMP_MIN, SMP_MAX, DIR_UP);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    settle();
    configure(MODE_PO, 24'sd3, 24'sd1, 24'sd0, S32_MAX, S32_MIN, -32'sd5000, 32'sd5000);
    send_sample(16'sd1, 16'sd0, DIR_UP);
    settle();
  endtask

  function automatic logic signed [GAIN_W-1:0] GAIN_I_DONT_CARE();
    return 24'sh5a5a5a;
  endfunction

  // Yaw: measurement and its difference only, error history left alone.
  task automatic test_yaw();
    configure(MODE_YAW, GAIN_MIN, GAIN_I_DONT_CARE(), GAIN_MAX, S32_MAX, S32_MIN,
              S32_MAX, S32_MIN);
    send_sample(SMP_MIN, 16'sd0, DIR_UP);
    send_sample(SMP_MAX, 16'sd0, DIR_UP);
    send_sample(16'sd0, 16'sd5, DIR_UP);
    settle();
  endtask

  // Unused mode codes repeat the last drive and leave all history as is.
  task automatic test_unused_modes();
    configure(MODE_POS, GAIN_ONE, 24'sd0, 24'sd0, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_sample(16'sd3, 16'sd20, DIR_UP);
    settle();
    configure(MODE_UNUSED_LO, GAIN_MAX, GAIN_MAX, GAIN_MAX, S32_MAX, S32_MIN,
              S32_MAX, S32_MIN);
    send_sample(SMP_MIN, SMP_MAX, DIR_FWD);
    settle();
    configure(MODE_UNUSED_HI, GAIN_MIN, GAIN_MIN, GAIN_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_sample(SMP_MAX, SMP_MIN, DIR_BACK);
    settle();
  endtask

  // Inverted drive window: big values get the upper bound, small ones the lower; then a proper window.
  task automatic test_clamp_order();
    configure(MODE_POS, GAIN_ONE, 24'sd0, 24'sd0, -32'sd100, 32'sd100, S32_MAX, S32_MIN);
    send_sample(SMP_MIN, SMP_MAX, DIR_UP);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    settle();
    configure(MODE_POS, GAIN_MIN, 24'sd0, 24'sd0, 32'sd4096, -32'sd4096, S32_MAX, S32_MIN);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    send_sample(16'sd0, 16'sd0, DIR_UP);
    settle();
  endtask

  // Receiver holds off for a long stretch while samples keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    configure(MODE_PO, GAIN_ONE, 24'sd16, 24'sd700, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    idle_on = 1'b0;
    long_hold_req = LONG_HOLD;
    repeat (10) send_sample(16'($urandom), 16'($urandom), 2'($urandom));
    idle_on = 1'b1;
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Random phases: fresh register setting per phase, random samples, mostly
  // tracking near the setpoint so the history terms stay meaningful.
  // ---------------------------------------------------------------------------
  task automatic test_random();
    logic [MODE_W-1:0] m;
    logic signed [GAIN_W-1:0] g [3];
    logic signed [DATA_W-1:0] dhi, dlo, ihi, ilo, tmp;
    logic signed [SAMPLE_W-1:0] meas, tgt;
    for (int phase = 0; phase < 12; phase++) begin
      if ($urandom_range(0, 9) == 0)
        m = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else
        m = MODE_W'($urandom_range(MODE_INC, MODE_YAW));
      foreach (g[k]) begin
        case ($urandom_range(0, 3))
          0:       g[k] = GAIN_W'($urandom);
          1:       g[k] = '0;
          default: g[k] = GAIN_W'(int'($urandom_range(0, 16383)) - 8192);
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        dhi = S32_MAX; dlo = S32_MIN;
      end else begin
        dhi = $urandom; dlo = $urandom;
        // mostly a proper window, sometimes left inverted
        if (dhi < dlo && $urandom_range(0, 3) != 0) begin
          tmp = dhi; dhi = dlo; dlo = tmp;
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        ihi = S32_MAX; ilo = S32_MIN;
      end else begin
        ihi = $urandom; ilo = $urandom;
        if (ihi < ilo && $urandom_range(0, 3) != 0) begin
          tmp = ihi; ihi = ilo; ilo = tmp;
        end
      end
      configure(m, g[0], g[1], g[2], dhi, dlo, ihi, ilo);
      tgt = SAMPLE_W'($urandom);
      repeat (50) begin
        if ($urandom_range(0, 7) == 0) tgt = SAMPLE_W'($urandom);
        case ($urandom_range(0, 7))
          0:       meas = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
          1, 2:    meas = SAMPLE_W'($urandom);
          default: meas = tgt + SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
        endcase
        send_sample(meas, ($urandom_range(0, 15) == 0) ? (meas ^ SMP_MIN) : tgt,
                    2'($urandom));
      end
      settle();
    end
  endtask

  // Error sum build-up: full positive error plus the forward bias grows the
  // sum fast, then one full negative step pulls it back by one error.
  // Run without any idling.
  task automatic test_sum_climb();
    idle_on = 1'b0;
    configure(MODE_BAL, 24'sd0, 24'sd1, 24'sd0, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    repeat (30) send_sample(SMP_MIN, SMP_MAX, DIR_FWD);
    send_sample(SMP_MAX, SMP_MIN, DIR_UP);
    send_sample(16'sd0, 16'sd0, DIR_UP);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_positional();
    test_incremental();
    test_balance();
    test_prop_outside();
    test_yaw();
    test_unused_modes();
    test_clamp_order();
    test_backpressure();
    test_random();
    test_sum_climb();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
